// ===== rtl/interval_booking_conflict_check_macros.svh =====
// Assertion macros used by the checker file of the booking table.
`ifndef INTERVAL_BOOKING_CONFLICT_CHECK_MACROS_SVH
`define INTERVAL_BOOKING_CONFLICT_CHECK_MACROS_SVH

// Checked on every rising edge outside reset.
`define IBCC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define IBCC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ibcc_pkg.sv =====
`default_nettype none

package ibcc_pkg;

  // Table size and time width.
  localparam int unsigned CAPACITY    = 1024;
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned COUNT_OUT_W = 11;
  localparam int unsigned ENTRY_W     = 2 * TIME_BITS;

  typedef logic [TIME_BITS-1:0]   time_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [COUNT_OUT_W-1:0] count_out_t;
  typedef logic [ENTRY_W-1:0]     entry_t;

  // Outcome codes of a request.
  typedef enum logic [1:0] {
    OUT_ACCEPTED = 2'd0,
    OUT_OVERLAP  = 2'd1,
    OUT_FULL     = 2'd2,
    OUT_INVALID  = 2'd3
  } outcome_e;

  // Request word.
  typedef struct packed {
    time_t start_time;
    time_t end_time;
  } req_t;

  // Result word.
  typedef struct packed {
    outcome_e   outcome;
    count_out_t stored_count;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ibcc_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module ibcc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/interval_booking_conflict_check.sv =====
// Channel | Direction | Handshake              | Word
// --------+-----------+------------------------+--------------------------------
// in      | input     | in_valid_i / in_ready_o  | ibcc_pkg::req_t (start, end)
// out     | output    | out_valid_o / out_ready_i| ibcc_pkg::rsp_t (outcome, count)
//
// One request is handled at a time. An invalid or full request goes straight to
// the result state. Otherwise the stored entries are read from the table memory
// one per cycle, and the scan stops at the first overlapping entry or after the
// last entry. The result word then waits for the output register to be free.
// Reset empties the table at once; no clearing pass is needed.
// A stalled result word sits in the output register while the next word is
// accepted and scanned; only its own result then waits for the register.
`default_nettype none

module interval_booking_conflict_check (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire ibcc_pkg::req_t   in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ibcc_pkg::rsp_t        out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e          state_q;
  ibcc_pkg::cnt_t  count_q;
  ibcc_pkg::cnt_t  idx_q;
  logic            chk_v_q;
  logic            out_valid_q;
  ibcc_pkg::req_t  req_q;
  ibcc_pkg::rsp_t  res_q;
  ibcc_pkg::rsp_t  out_data_q;

  logic            in_acc;
  logic            req_invalid;
  logic            table_full;
  logic            rd_en;
  logic            hit;
  logic            scan_done;
  logic            out_load;
  ibcc_pkg::cnt_t  count_inc;
  ibcc_pkg::entry_t rd_data;
  ibcc_pkg::time_t mem_start;
  ibcc_pkg::time_t mem_end;

  // Table memory: each entry holds the start and end of one interval.
  ibcc_ram #(
    .Width (ibcc_pkg::ENTRY_W),
    .Depth (ibcc_pkg::CAPACITY)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (scan_done),
    .wr_addr_i (count_q[ibcc_pkg::ADDR_W-1:0]),
    .wr_data_i ({req_q.start_time, req_q.end_time}),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[ibcc_pkg::ADDR_W-1:0]),
    .rd_data_o (rd_data)
  );

  assign mem_start = rd_data[ibcc_pkg::ENTRY_W-1:ibcc_pkg::TIME_BITS];
  assign mem_end   = rd_data[ibcc_pkg::TIME_BITS-1:0];

  // Request checks at acceptance.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign req_invalid = (in_data_i.start_time >= in_data_i.end_time);
  assign table_full  = (count_q == ibcc_pkg::cnt_t'(ibcc_pkg::CAPACITY));
  assign count_inc   = count_q + ibcc_pkg::cnt_t'(1);

  // Scan: issue one read a cycle and test the word read in the cycle before.
  assign rd_en     = (state_q == ST_SCAN) && (idx_q < count_q);
  assign hit       = (state_q == ST_SCAN) && chk_v_q &&
                     (req_q.start_time < mem_end) && (mem_start < req_q.end_time);
  assign scan_done = (state_q == ST_SCAN) && !hit && !rd_en && !chk_v_q;

  // The pending result moves to the output register once that is free.
  assign out_load = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  // Control state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      chk_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            idx_q   <= '0;
            chk_v_q <= 1'b0;
            state_q <= (req_invalid || table_full) ? ST_RESP : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            idx_q <= idx_q + ibcc_pkg::cnt_t'(1);
          end
          chk_v_q <= rd_en;
          if (scan_done) begin
            count_q <= count_inc;
          end
          if (hit || scan_done) begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, pending result and output word.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q              <= in_data_i;
      res_q.outcome      <= req_invalid ? ibcc_pkg::OUT_INVALID : ibcc_pkg::OUT_FULL;
      res_q.stored_count <= ibcc_pkg::count_out_t'(count_q);
    end
    if (hit) begin
      res_q.outcome      <= ibcc_pkg::OUT_OVERLAP;
      res_q.stored_count <= ibcc_pkg::count_out_t'(count_q);
    end
    if (scan_done) begin
      res_q.outcome      <= ibcc_pkg::OUT_ACCEPTED;
      res_q.stored_count <= ibcc_pkg::count_out_t'(count_inc);
    end
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/ibcc_assert.sv =====
`default_nettype none
`include "interval_booking_conflict_check_macros.svh"

// Port-level checks on the booking table.
module ibcc_assert (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire ibcc_pkg::rsp_t out_data_o
);

  logic out_stall;
  logic in_take;
  logic full_shown;
  logic full_count_ok;

  assign out_stall     = out_valid_o && !out_ready_i;
  assign in_take       = in_valid_i && in_ready_o;
  assign full_shown    = out_valid_o && (out_data_o.outcome == ibcc_pkg::OUT_FULL);
  assign full_count_ok =
      (out_data_o.stored_count == ibcc_pkg::count_out_t'(ibcc_pkg::CAPACITY));

  // A stalled result word holds.
  `IBCC_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> $stable({out_valid_o, out_data_o}), "held word changed")

  // Requests are handled one at a time.
  `IBCC_ASSERT(a_one_at_a_time, clk_i, rst_ni, in_take |=> !in_ready_o, "request taken while busy")

  // A full refusal reports the whole capacity as stored.
  `IBCC_ASSERT(a_full_count, clk_i, rst_ni, full_shown |-> full_count_ok, "full refusal with wrong count")

  // During reset no result is shown and requests may be taken.
  `IBCC_ASSERT_ALWAYS(a_reset_state, clk_i, !rst_ni |-> !out_valid_o && in_ready_o, "bad reset state")

endmodule

bind interval_booking_conflict_check ibcc_assert u_ibcc_assert (.*);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT      = 20000;
  localparam int unsigned SETTLE_CYCLES    = ibcc_pkg::CAPACITY + 100;
  localparam int unsigned RANDOM_ITEMS     = 400;

  logic           clk;
  logic           rst_n     = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  ibcc_pkg::req_t in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  ibcc_pkg::rsp_t out_data;

  // Predicted contents of the booking table.
  ibcc_pkg::time_t booked_starts [ibcc_pkg::CAPACITY];
  ibcc_pkg::time_t booked_ends   [ibcc_pkg::CAPACITY];
  int              booked_count = 0;

  // Results still owed by the block, oldest first, with the words that caused them.
  ibcc_pkg::rsp_t pending_results  [$];
  ibcc_pkg::req_t pending_requests [$];

  int unsigned error_count     = 0;
  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned outcome_tally [4] = '{0, 0, 0, 0};
  int unsigned longest_stall   = 0;
  bit          gaps_off        = 1'b0;
  bit          hold_request    = 1'b0;

  interval_booking_conflict_check i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Safety net in case the block stops answering.
  initial begin
    #(64'd200_000_000);
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Index of the first stored interval that meets [s, e), or -1.
  function automatic int clash_index(input ibcc_pkg::time_t s, input ibcc_pkg::time_t e);
    for (int i = 0; i < booked_count; i++) begin
      if (s < booked_ends[i] && booked_starts[i] < e) return i;
    end
    return -1;
  endfunction

  // Lowest start at or after 'from' where an interval of length len fits, wrapping to zero at the top.
  function automatic ibcc_pkg::time_t free_start(input ibcc_pkg::time_t from,
                                                 input ibcc_pkg::time_t len);
    ibcc_pkg::time_t s;
    int              k;
    s = from;
    for (int tries = 0; tries < 4096; tries++) begin
      if (ibcc_pkg::time_t'(s + len) < s) s = '0;
      k = clash_index(s, ibcc_pkg::time_t'(s + len));
      if (k < 0) return s;
      s = booked_ends[k];
    end
    return s;
  endfunction

  // Decide one request against the predicted table and update it.
  function automatic ibcc_pkg::rsp_t book_interval(input ibcc_pkg::req_t req);
    ibcc_pkg::rsp_t rsp;
    rsp.outcome = ibcc_pkg::OUT_ACCEPTED;
    if (req.start_time >= req.end_time) begin
      rsp.outcome = ibcc_pkg::OUT_INVALID;
    end else if (booked_count >= ibcc_pkg::CAPACITY) begin
      rsp.outcome = ibcc_pkg::OUT_FULL;
    end else if (clash_index(req.start_time, req.end_time) >= 0) begin
      rsp.outcome = ibcc_pkg::OUT_OVERLAP;
    end else begin
      booked_starts[booked_count] = req.start_time;
      booked_ends[booked_count]   = req.end_time;
      booked_count++;
    end
    rsp.stored_count = ibcc_pkg::count_out_t'(booked_count);
    return rsp;
  endfunction

  // Offer one request word and record what it should produce once taken.
  task automatic send_request(input ibcc_pkg::time_t s, input ibcc_pkg::time_t e);
    int unsigned    gap;
    ibcc_pkg::req_t req;
    ibcc_pkg::rsp_t want;
    gap            = gaps_off ? 0 : pick_gap();
    req.start_time = s;
    req.end_time   = e;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want             = book_interval(req);
    pending_results  = {pending_results, want};
    pending_requests = {pending_requests, req};
    requests_sent++;
  endtask

  // Stop offering and let every owed result come back.
  task automatic wait_for_results();
    int unsigned waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Output ready: random stalls, plus one long hold when a test asks for it.
  initial begin : result_ready_driver
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned run_left;
    logic        ready_next;
    hold_left  = 0;
    stall_left = 0;
    run_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD_CYCLES - 1;
        ready_next   = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        ready_next = 1'b1;
      end else begin
        run_left   = $urandom_range(0, 30);
        stall_left = gaps_off ? 0 : pick_gap();
        ready_next = (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
      out_ready <= ready_next;
    end
  end

  // Compare each result word taken with the oldest prediction.
  initial begin : result_checker
    ibcc_pkg::rsp_t want;
    ibcc_pkg::req_t req;
    int unsigned    stall_run;
    stall_run = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_ready) begin
        stall_run++;
        if (stall_run > longest_stall) longest_stall = stall_run;
      end else begin
        stall_run = 0;
      end
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result word (outcome %0d, count %0d) with no request owed",
                                    out_data.outcome, out_data.stored_count));
        end else begin
          want = pending_results.pop_front();
          req  = pending_requests.pop_front();
          if (out_data.outcome !== want.outcome) begin
            report_mismatch($sformatf("[%h, %h): outcome %0d, expected %0d",
                                      req.start_time, req.end_time,
                                      out_data.outcome, want.outcome));
          end
          if (out_data.stored_count !== want.stored_count) begin
            report_mismatch($sformatf("[%h, %h): stored count %0d, expected %0d",
                                      req.start_time, req.end_time,
                                      out_data.stored_count, want.stored_count));
          end
          outcome_tally[want.outcome]++;
          results_checked++;
        end
      end
    end
  end

  // Edges of the time range, touching neighbours, partial and full overlaps, bad intervals.
  task automatic test_directed_cases();
    send_request(32'h0000_0000, 32'h0000_0001);
    send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(32'h0000_0001, 32'h0000_0002);
    send_request(32'hFFFF_FFFD, 32'hFFFF_FFFE);
    send_request(32'h0000_0000, 32'h0000_0001);
    send_request(32'h0000_0000, 32'hFFFF_FFFF);
    send_request(32'h0000_0001, 32'hFFFF_FFFD);
    send_request(32'hFFFF_FFFC, 32'hFFFF_FFFE);
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'h0000_0000);
    send_request(32'hAAAA_AAAA, 32'h5555_5555);
    send_request(32'h5555_5555, 32'h5555_5555);
    send_request(32'h0000_1000, 32'h0000_1010);
    send_request(32'h0000_1005, 32'h0000_1006);
    send_request(32'h0000_0FF5, 32'h0000_1001);
    send_request(32'h0000_100F, 32'h0000_1020);
    send_request(32'h0000_0FF0, 32'h0000_1000);
    send_request(32'h0000_1010, 32'h0000_1011);
    send_request(32'h7FFF_FFFF, 32'h8000_0000);
    send_request(32'h7FFF_FFFE, 32'h8000_0001);
    wait_for_results();
  endtask

  // Hold the output off for a long stretch while words keep arriving.
  task automatic test_back_pressure();
    ibcc_pkg::time_t s;
    gaps_off     = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < 6; i++) begin
      s = free_start(32'h0000_2000, 3);
      send_request(s, s + 3);
    end
    gaps_off = 1'b0;
    wait_for_results();
  endtask

  // Mostly fresh bookings and probes around stored entries, with bad words and noise.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned     roll;
    int unsigned     k;
    int unsigned     d;
    ibcc_pkg::time_t s;
    ibcc_pkg::time_t e;
    ibcc_pkg::time_t len;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 50 == 0) gaps_off = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      k    = $urandom_range(0, booked_count - 1);
      d    = $urandom_range(1, 40);
      if (roll < 40) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 100000) : $urandom_range(1, 16);
        s   = free_start(booked_ends[k] + $urandom_range(0, 3), len);
        e   = s + len;
      end else if (roll < 70) begin
        case ($urandom_range(0, 5))
          0: begin
            s = booked_starts[k];
            e = booked_ends[k];
          end
          1: begin
            s = booked_starts[k] - d;
            e = booked_starts[k] + 1;
          end
          2: begin
            s = booked_ends[k] - 1;
            e = booked_ends[k] + d;
          end
          3: begin
            s = booked_starts[k] - d;
            e = booked_starts[k];
          end
          4: begin
            s = booked_ends[k];
            e = booked_ends[k] + d;
          end
          default: begin
            s = booked_starts[k];
            e = booked_starts[k] + 1;
          end
        endcase
      end else if (roll < 80) begin
        s = $urandom;
        e = s - $urandom_range(0, 3);
      end else begin
        s = $urandom;
        e = $urandom;
      end
      send_request(s, e);
    end
    gaps_off = 1'b0;
    wait_for_results();
  endtask

  // Pack short intervals until the table holds its full capacity.
  task automatic test_fill_to_capacity();
    ibcc_pkg::time_t s;
    ibcc_pkg::time_t len;
    ibcc_pkg::time_t cursor;
    cursor = 32'h4000_0000;
    while (booked_count < ibcc_pkg::CAPACITY) begin
      len = $urandom_range(1, 4);
      s   = free_start(cursor, len);
      send_request(s, s + len);
      cursor = s + len + $urandom_range(0, 2);
      // Now and then straddle the last unit of the entry just booked.
      if ($urandom_range(0, 19) == 0) send_request(s + len - 1, s + len + 1);
    end
    wait_for_results();
  endtask

  // With the table full, good words are refused as full and bad ones still as invalid.
  task automatic test_full_table();
    ibcc_pkg::time_t s;
    s = free_start(32'h9000_0000, 8);
    send_request(s, s + 8);
    send_request(booked_starts[0], booked_ends[0]);
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 32'h0000_0000);
    for (int i = 0; i < 12; i++) send_request($urandom, $urandom);
    wait_for_results();
  endtask

  // Test sequence.
  initial begin
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    test_directed_cases();
    test_back_pressure();
    test_random_traffic(RANDOM_ITEMS);
    test_fill_to_capacity();
    test_full_table();

    // Give any stray result word time to show up.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("Sent %0d requests, checked %0d results: %0d accepted, %0d overlapping, %0d full, %0d invalid",
             requests_sent, results_checked, outcome_tally[ibcc_pkg::OUT_ACCEPTED],
             outcome_tally[ibcc_pkg::OUT_OVERLAP], outcome_tally[ibcc_pkg::OUT_FULL],
             outcome_tally[ibcc_pkg::OUT_INVALID]);
    $display("Table filled to %0d of %0d entries; longest output stall %0d cycles; %0d mismatches",
             booked_count, ibcc_pkg::CAPACITY, longest_stall, error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
